@@ src/kswtp_pkg.sv @@
// package with shared constants, types and register codes of the key search block
`default_nettype none

package kswtp_pkg;

  // key and stream geometry
  localparam int KeyMax    = 16;
  localparam int StreamMax = 4096;
  localparam int CountCap  = StreamMax + KeyMax;

  // field and internal widths
  localparam int ByteW  = 8;
  localparam int LenW   = 5;
  localparam int StartW = 12;
  localparam int CntW   = $clog2(CountCap + 1);
  localparam int PosW   = $clog2(StreamMax);
  localparam int KIdxW  = (KeyMax > 1) ? $clog2(KeyMax) : 1;
  localparam int WordW  = 64;
  localparam int CfgIdxW = 2;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgKeyLow    = 2'd0,
    CfgKeyHigh   = 2'd1,
    CfgKeyLength = 2'd2,
    CfgPartial   = 2'd3
  } cfg_idx_e;

  typedef logic [KeyMax-1:0][ByteW-1:0] key_arr_t;

  // configuration as seen by the search logic
  typedef struct packed {
    key_arr_t        key;
    logic [LenW-1:0] key_len;
    logic            allow_partial;
  } cfg_t;

  // per-cell control from the top level
  typedef struct packed {
    logic shift;
    logic fill_in;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ src/kswtp_cfg.sv @@
// configuration register file of the key search block
`default_nettype none

module kswtp_cfg (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire  [kswtp_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire  [kswtp_pkg::WordW-1:0]     cfg_data_i,
  output kswtp_pkg::cfg_t                 cfg_o
);
  import kswtp_pkg::*;

  logic [WordW-1:0] key_low_q, key_low_d;
  logic [WordW-1:0] key_high_q, key_high_d;
  logic [LenW-1:0]  key_len_q, key_len_d;
  logic             allow_q, allow_d;
  logic             wr;
  logic [2*WordW-1:0] key_word;

  assign cfg_ready_o = 1'b1;
  assign wr = cfg_valid_i;

  // register write decode
  always_comb begin
    key_low_d  = key_low_q;
    key_high_d = key_high_q;
    key_len_d  = key_len_q;
    allow_d    = allow_q;
    if (wr) begin
      unique case (cfg_index_i)
        CfgKeyLow:    key_low_d  = cfg_data_i;
        CfgKeyHigh:   key_high_d = cfg_data_i;
        CfgKeyLength: key_len_d  = cfg_data_i[LenW-1:0];
        CfgPartial:   allow_d    = cfg_data_i[0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
      key_len_q  <= '0;
      allow_q    <= 1'b1;
    end else begin
      key_low_q  <= key_low_d;
      key_high_q <= key_high_d;
      key_len_q  <= key_len_d;
      allow_q    <= allow_d;
    end
  end

  // key bytes and effective length, lengths above the maximum clip
  assign key_word = {key_high_q, key_low_q};

  always_comb begin
    for (int j = 0; j < KeyMax; j++) begin
      cfg_o.key[j] = key_word[ByteW*j +: ByteW];
    end
    cfg_o.key_len = (key_len_q > LenW'(KeyMax)) ? LenW'(KeyMax) : key_len_q;
    cfg_o.allow_partial = allow_q;
  end

endmodule

`default_nettype wire

@@ src/kswtp_cell.sv @@
// one window cell: holds a stream byte and compares it against every key byte
`default_nettype none

module kswtp_cell (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  kswtp_pkg::cell_ctrl_t         ctrl_i,
  input  wire  [kswtp_pkg::ByteW-1:0]   byte_i,
  input  kswtp_pkg::key_arr_t           key_i,
  output logic [kswtp_pkg::ByteW-1:0]   byte_o,
  output logic                          fill_o,
  output logic [kswtp_pkg::KeyMax-1:0]  eq_o
);
  import kswtp_pkg::*;

  logic [ByteW-1:0] byte_q, byte_d;
  logic             fill_q, fill_d;

  // shift from the neighbor on every transfer
  always_comb begin
    byte_d = byte_q;
    fill_d = fill_q;
    if (ctrl_i.shift) begin
      byte_d = byte_i;
      fill_d = ctrl_i.fill_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign byte_o = byte_q;
  assign fill_o = fill_q;

  // compare against all key bytes, empty slots never match
  always_comb begin
    for (int j = 0; j < KeyMax; j++) begin
      eq_o[j] = fill_q && (byte_q == key_i[j]);
    end
  end

endmodule

`default_nettype wire

@@ src/key_search_with_tail_prefix.sv @@
// top level of the key search with tail prefix match
// output: the last byte's evaluation state is registered, then the result register
// throughput: one byte per cycle; input stalls only while a finished result is
//   stalled at the output and the next stream end is already being evaluated
// reset: asynchronous active low, clears window fill flags, counters, result valid and
//   configuration (key zero, key length zero, partial tail mode on)
`default_nettype none

module key_search_with_tail_prefix (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             in_valid_i,
  output logic                            in_stall_o,
  input  wire  [kswtp_pkg::ByteW-1:0]     data_byte_i,
  input  wire                             last_byte_i,
  output logic                            out_valid_o,
  input  wire                             out_stall_i,
  output logic                            found_o,
  output logic [kswtp_pkg::StartW-1:0]    start_position_o,
  output logic [kswtp_pkg::LenW-1:0]      matched_length_o,
  output logic                            length_overflow_o,
  input  wire                             cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire  [kswtp_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire  [kswtp_pkg::WordW-1:0]     cfg_data_i
);
  import kswtp_pkg::*;

  cfg_t             cfg;
  logic             in_xfer;
  logic             hold;
  logic             fire;

  // stream tracking
  logic             restart_q, restart_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             eval_valid_q, eval_valid_d;
  logic             eval_last_q, eval_last_d;
  logic             full_found_q, full_found_d;
  logic [PosW-1:0]  full_pos_q, full_pos_d;

  // result register
  logic              out_valid_q, out_valid_d;
  logic              found_q, found_d;
  logic [StartW-1:0] start_q, start_d;
  logic [LenW-1:0]   mlen_q, mlen_d;
  logic              ovf_q, ovf_d;

  // window cells
  cell_ctrl_t        ctrl [KeyMax];
  logic [ByteW-1:0]  cell_byte [KeyMax];
  logic              cell_fill [KeyMax];
  logic [KeyMax-1:0] cell_eq [KeyMax];

  // match evaluation
  logic [KeyMax-1:0] pm;
  logic [LenW-1:0]   k;
  logic [LenW-1:0]   k_m1;
  logic [LenW-1:0]   best;
  logic [CntW-1:0]   st_full;
  logic [CntW-1:0]   st_part;
  logic              full_hit;
  logic              part_ok;

  kswtp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // handshake: hold the evaluated stream end while the result slot is busy
  assign hold       = eval_valid_q && eval_last_q && out_valid_q && out_stall_i;
  assign in_stall_o = hold;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign fire       = eval_valid_q && !hold;

  // chain of cells, a new stream drops the old contents
  for (genvar i = 0; i < KeyMax; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign ctrl[i].shift   = in_xfer;
      assign ctrl[i].fill_in = 1'b1;
      kswtp_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctrl_i (ctrl[i]),
        .byte_i (data_byte_i),
        .key_i  (cfg.key),
        .byte_o (cell_byte[i]),
        .fill_o (cell_fill[i]),
        .eq_o   (cell_eq[i])
      );
    end else begin : g_body
      assign ctrl[i].shift   = in_xfer;
      assign ctrl[i].fill_in = cell_fill[i-1] && !restart_q;
      kswtp_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctrl_i (ctrl[i]),
        .byte_i (cell_byte[i-1]),
        .key_i  (cfg.key),
        .byte_o (cell_byte[i]),
        .fill_o (cell_fill[i]),
        .eq_o   (cell_eq[i])
      );
    end
  end

  // prefix of length l+1 matches when cell c holds key byte l-c
  always_comb begin
    for (int l = 0; l < KeyMax; l++) begin
      pm[l] = 1'b1;
      for (int c = 0; c <= l; c++) begin
        pm[l] = pm[l] & cell_eq[c][l-c];
      end
    end
  end

  // full match and longest proper tail prefix
  always_comb begin
    k       = cfg.key_len;
    k_m1    = k - LenW'(1);
    st_full = cnt_q - CntW'(k);
    full_hit = !full_found_q && (k != '0) && pm[k_m1[KIdxW-1:0]]
               && (st_full < CntW'(StreamMax));
    best = '0;
    for (int l = 0; l < KeyMax; l++) begin
      if ((LenW'(l + 1) < k) && pm[l]) begin
        best = LenW'(l + 1);
      end
    end
    st_part = cnt_q - CntW'(best);
    part_ok = cfg.allow_partial && (best != '0) && (st_part < CntW'(StreamMax));
  end

  // stream state next values
  always_comb begin
    restart_d    = restart_q;
    cnt_d        = cnt_q;
    eval_valid_d = eval_valid_q;
    eval_last_d  = eval_last_q;
    full_found_d = full_found_q;
    full_pos_d   = full_pos_q;
    if (fire) begin
      eval_valid_d = 1'b0;
      if (eval_last_q) begin
        full_found_d = 1'b0;
        full_pos_d   = '0;
      end else if (full_hit) begin
        full_found_d = 1'b1;
        full_pos_d   = st_full[PosW-1:0];
      end
    end
    if (in_xfer) begin
      restart_d    = last_byte_i;
      eval_valid_d = 1'b1;
      eval_last_d  = last_byte_i;
      if (restart_q) begin
        cnt_d = CntW'(1);
      end else if (cnt_q < CntW'(CountCap)) begin
        cnt_d = cnt_q + CntW'(1);
      end
    end
  end

  // result register next values
  always_comb begin
    out_valid_d = out_valid_q;
    found_d     = found_q;
    start_d     = start_q;
    mlen_d      = mlen_q;
    ovf_d       = ovf_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (fire && eval_last_q) begin
      out_valid_d = 1'b1;
      ovf_d       = cnt_q > CntW'(StreamMax);
      priority if (full_found_q) begin
        found_d = 1'b1;
        start_d = StartW'(full_pos_q);
        mlen_d  = k;
      end else if (full_hit) begin
        found_d = 1'b1;
        start_d = st_full[StartW-1:0];
        mlen_d  = k;
      end else if (part_ok) begin
        found_d = 1'b1;
        start_d = st_part[StartW-1:0];
        mlen_d  = best;
      end else begin
        found_d = 1'b0;
        start_d = '0;
        mlen_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_q    <= 1'b0;
      cnt_q        <= '0;
      eval_valid_q <= 1'b0;
      eval_last_q  <= 1'b0;
      full_found_q <= 1'b0;
      full_pos_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      restart_q    <= restart_d;
      cnt_q        <= cnt_d;
      eval_valid_q <= eval_valid_d;
      eval_last_q  <= eval_last_d;
      full_found_q <= full_found_d;
      full_pos_q   <= full_pos_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q <= found_d;
    start_q <= start_d;
    mlen_q  <= mlen_d;
    ovf_q   <= ovf_d;
  end

  assign out_valid_o       = out_valid_q;
  assign found_o           = found_q;
  assign start_position_o  = start_q;
  assign matched_length_o  = mlen_q;
  assign length_overflow_o = ovf_q;

  // input stalls only behind a stream end waiting for the result slot
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (eval_valid_q && eval_last_q && out_valid_q))
    else $error("input stalled without a pending stream end");

  // a delivered stream end clears the latched full match
  a_stream_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && eval_last_q) |=> (!full_found_q && out_valid_q))
    else $error("stream state not cleared after stream end");

  // not found reports zero position and length
  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (start_position_o == '0 && matched_length_o == '0))
    else $error("not found result carries position or length");

  // a found result has a nonzero length within the key size
  a_found_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && found_o) |->
      (matched_length_o != '0 && matched_length_o <= LenW'(KeyMax)))
    else $error("found result with bad matched length");

endmodule

`default_nettype wire
